>>> sv/elev_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elev_pkg
// Types, codes and helpers shared by the elevator controller and its checker.
// ----------------------------------------------------------------------------
package elev_pkg;

  localparam int unsigned FLOORS = 4;
  localparam logic [3:0]  VALID_MASK = 4'((1 << FLOORS) - 1);

  localparam logic        OP_TICK  = 1'b0;
  localparam logic        OP_PRESS = 1'b1;

  // Phase codes as shown on the result channel
  localparam logic [3:0]  PH_IDLE        = 4'd0;
  localparam logic [3:0]  PH_COLLECT     = 4'd1;
  localparam logic [3:0]  PH_START_CLOSE = 4'd2;
  localparam logic [3:0]  PH_CLOSING     = 4'd3;
  localparam logic [3:0]  PH_CHOOSE      = 4'd4;
  localparam logic [3:0]  PH_TRAVEL      = 4'd5;
  localparam logic [3:0]  PH_ARRIVE      = 4'd6;
  localparam logic [3:0]  PH_OPENING     = 4'd7;
  localparam logic [3:0]  PH_DWELL       = 4'd8;

  localparam logic [1:0]  DIR_STOP = 2'd0;
  localparam logic [1:0]  DIR_LOW  = 2'd1;
  localparam logic [1:0]  DIR_HIGH = 2'd2;

  localparam logic [6:0]  DUTY_OFF   = 7'd0;
  localparam logic [6:0]  DUTY_UP    = 7'd80;
  localparam logic [6:0]  DUTY_DOWN  = 7'd60;
  localparam logic [6:0]  DUTY_CLOSE = 7'd50;
  localparam logic [6:0]  DUTY_OPEN  = 7'd60;

  localparam logic [15:0] TIMER_MAX       = 16'hFFFF;
  localparam logic [15:0] RST_SETTLE      = 16'd1000;
  localparam logic [15:0] RST_CLOSE       = 16'd4000;
  localparam logic [15:0] RST_TRAVEL      = 16'd6000;
  localparam logic [15:0] RST_OPEN        = 16'd4000;
  localparam logic [15:0] RST_DWELL       = 16'd2000;
  localparam logic [15:0] RST_LIGHT_STEP  = 16'd200;

  localparam logic [2:0]  UP_POS_FIRST   = 3'd4;
  localparam logic [2:0]  UP_POS_LAST    = 3'd7;
  localparam logic [2:0]  DOWN_POS_FIRST = 3'd7;
  localparam logic [2:0]  DOWN_POS_LAST  = 3'd4;

  typedef enum logic [2:0] {
    CFG_SETTLE     = 3'd0,
    CFG_CLOSE      = 3'd1,
    CFG_TRAVEL     = 3'd2,
    CFG_OPEN       = 3'd3,
    CFG_DWELL      = 3'd4,
    CFG_LIGHT_STEP = 3'd5
  } cfg_idx_t;

  // Waiting phases only; start-close, choose and arrive never outlast a tick
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_COLLECT = 6'b000010,
    ST_CLOSING = 6'b000100,
    ST_TRAVEL  = 6'b001000,
    ST_OPENING = 6'b010000,
    ST_DWELL   = 6'b100000
  } state_t;

  typedef struct packed {
    logic up;
    logic dn;
  } dir_sel_t;

  function automatic logic [3:0] floor_bit(input logic [2:0] flr);
    return 4'b0001 << ((flr - 3'd1) & 3'd3);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == TIMER_MAX) ? v : v + 16'd1;
  endfunction

  function automatic dir_sel_t choose_dir(input logic [3:0] mask, input logic [2:0] flr);
    dir_sel_t res;
    res.up = (mask > floor_bit(flr)) && (flr < 3'(FLOORS));
    res.dn = !res.up && (mask < floor_bit(flr)) && (flr > 3'd1);
    return res;
  endfunction

  // Nearest requested floor in the travel direction
  function automatic logic [2:0] target_floor(input logic [3:0] mask, input logic [2:0] flr,
                                              input logic up);
    logic [2:0] res;
    logic       found;
    res   = flr;
    found = 1'b0;
    for (int i = 0; i < FLOORS; i++) begin
      if (mask[i]) begin
        if (up && !found && (3'(i + 1) > flr)) begin
          res   = 3'(i + 1);
          found = 1'b1;
        end
        if (!up && (3'(i + 1) < flr)) begin
          res = 3'(i + 1);
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/elevator_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_controller_core
// Four-floor elevator sequencer driven by millisecond ticks and button items.
// ----------------------------------------------------------------------------
// Each input item (a tick or a button press) is taken on a handshake and its
// result, the controller state after the item, appears on the output in the
// following clock. One item per clock is sustained; in_ready drops only while
// a result is held by out_ready low. The rate is set by the combinational
// next-state logic, which resolves a whole tick (including zero-length timed
// phases and multi-floor moves) in one pass. Configuration writes take effect
// on the next clock; there is no start-up sweep.
module elevator_controller_core
  import elev_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_button_floor,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_floor_now,
  output logic [3:0]       out_phase,
  output logic [7:0]       out_led_pattern,
  output logic [1:0]       out_direction_line,
  output logic [6:0]       out_motor_duty,
  output logic [6:0]       out_door_duty,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] settle_r, close_r, travel_r, open_r, dwell_r, step_r;

  state_t      st_r, st_nxt;
  logic [2:0]  floor_r, floor_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic        up_r, up_nxt;
  logic        dn_r, dn_nxt;
  logic [15:0] ptmr_r, ptmr_nxt;
  logic [15:0] ltmr_r, ltmr_nxt;
  logic [2:0]  upos_r, upos_nxt;
  logic [2:0]  dpos_r, dpos_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic [6:0]  motor_r, motor_nxt;
  logic [6:0]  door_r, door_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= RST_SETTLE;
      close_r  <= RST_CLOSE;
      travel_r <= RST_TRAVEL;
      open_r   <= RST_OPEN;
      dwell_r  <= RST_DWELL;
      step_r   <= RST_LIGHT_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:     settle_r <= cfg_wdata;
        CFG_CLOSE:      close_r  <= cfg_wdata;
        CFG_TRAVEL:     travel_r <= cfg_wdata;
        CFG_OPEN:       open_r   <= cfg_wdata;
        CFG_DWELL:      dwell_r  <= cfg_wdata;
        CFG_LIGHT_STEP: step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state for one item, with every zero-wait phase resolved in this pass
  always_comb begin
    logic       do_choose, do_travel, do_light, do_stop, do_dwell, do_idle;
    logic [3:0] add;
    logic [3:0] btn_bit;
    logic [2:0] f1;
    dir_sel_t   dsel;

    do_choose = 1'b0;
    do_travel = 1'b0;
    do_light  = 1'b0;
    do_stop   = 1'b0;
    do_dwell  = 1'b0;
    do_idle   = 1'b0;
    add       = 4'd0;
    btn_bit   = 4'd0;
    f1        = floor_r;
    dsel      = '0;

    st_nxt    = st_r;
    floor_nxt = floor_r;
    mask_nxt  = mask_r;
    pend_nxt  = pend_r;
    up_nxt    = up_r;
    dn_nxt    = dn_r;
    ptmr_nxt  = ptmr_r;
    ltmr_nxt  = ltmr_r;
    upos_nxt  = upos_r;
    dpos_nxt  = dpos_r;
    nib_nxt   = nib_r;
    dir_nxt   = dir_r;
    motor_nxt = motor_r;
    door_nxt  = door_r;

    if (in_fire) begin
      if (in_op == OP_PRESS) begin
        btn_bit = 4'b0001 << in_button_floor;
        if ((st_r == ST_IDLE) || (st_r == ST_COLLECT)) begin
          add = btn_bit & VALID_MASK & ~floor_bit(floor_r);
          if (add != 4'd0) begin
            mask_nxt = mask_r | add;
            ptmr_nxt = 16'd0;
            st_nxt   = ST_COLLECT;
          end
        end else begin
          pend_nxt = pend_r | btn_bit;
        end
      end else begin
        ptmr_nxt = sat_inc(ptmr_r);
        ltmr_nxt = sat_inc(ltmr_r);

        case (st_r)
          ST_IDLE: ;
          ST_COLLECT: begin
            if (ptmr_nxt > settle_r) begin
              dir_nxt  = DIR_LOW;
              door_nxt = DUTY_CLOSE;
              ptmr_nxt = 16'd0;
              st_nxt   = ST_CLOSING;
            end
          end
          ST_CLOSING: begin
            if (ptmr_nxt > close_r) begin
              dir_nxt   = DIR_STOP;
              door_nxt  = DUTY_OFF;
              do_choose = 1'b1;
            end
          end
          ST_TRAVEL: do_travel = 1'b1;
          ST_OPENING: begin
            if (ptmr_nxt >= open_r) begin
              dir_nxt  = DIR_STOP;
              door_nxt = DUTY_OFF;
              ptmr_nxt = 16'd0;
              st_nxt   = ST_DWELL;
              do_dwell = 1'b1;
            end
          end
          ST_DWELL: do_dwell = 1'b1;
          default: do_idle = 1'b1;
        endcase

        if (do_choose) begin
          dsel = choose_dir(mask_nxt, floor_nxt);
          if (dsel.up) begin
            up_nxt    = 1'b1;
            dir_nxt   = DIR_HIGH;
            motor_nxt = DUTY_UP;
          end else if (dsel.dn) begin
            dn_nxt    = 1'b1;
            dir_nxt   = DIR_LOW;
            motor_nxt = DUTY_DOWN;
          end
          ptmr_nxt  = 16'd0;
          st_nxt    = ST_TRAVEL;
          do_travel = 1'b1;
        end

        if (do_travel) begin
          if (ptmr_nxt >= travel_r) begin
            // Arrive: move one floor in the current direction
            f1 = floor_nxt;
            if (up_nxt) begin
              if (f1 < 3'(FLOORS)) f1 = f1 + 3'd1;
            end else if (dn_nxt) begin
              if (f1 > 3'd1) f1 = f1 - 3'd1;
            end
            floor_nxt = f1;
            up_nxt    = 1'b0;
            dn_nxt    = 1'b0;
            dir_nxt   = DIR_STOP;
            motor_nxt = DUTY_OFF;
            nib_nxt   = 4'd0;
            upos_nxt  = UP_POS_FIRST;
            dpos_nxt  = DOWN_POS_FIRST;
            if ((mask_nxt & floor_bit(f1)) != 4'd0) begin
              do_stop = 1'b1;
            end else begin
              // Not requested here: pick a direction again
              dsel = choose_dir(mask_nxt, f1);
              ptmr_nxt = 16'd0;
              st_nxt   = ST_TRAVEL;
              if (travel_r == 16'd0) begin
                // Zero travel time: skip straight to the next requested floor
                floor_nxt = target_floor(mask_nxt, f1, dsel.up);
                do_stop   = 1'b1;
              end else begin
                if (dsel.up) begin
                  up_nxt    = 1'b1;
                  dir_nxt   = DIR_HIGH;
                  motor_nxt = DUTY_UP;
                end else if (dsel.dn) begin
                  dn_nxt    = 1'b1;
                  dir_nxt   = DIR_LOW;
                  motor_nxt = DUTY_DOWN;
                end
                do_light = 1'b1;
              end
            end
          end else begin
            do_light = 1'b1;
          end
        end

        if (do_light && (ltmr_nxt >= step_r)) begin
          ltmr_nxt = 16'd0;
          if (up_nxt) begin
            nib_nxt  = 4'b0001 << upos_nxt[1:0];
            upos_nxt = (upos_nxt >= UP_POS_LAST) ? UP_POS_FIRST
                                                 : {1'b1, upos_nxt[1:0]} + 3'd1;
          end else if (dn_nxt) begin
            nib_nxt  = 4'b0001 << dpos_nxt[1:0];
            dpos_nxt = (dpos_nxt <= DOWN_POS_LAST) ? DOWN_POS_FIRST
                                                   : {1'b1, dpos_nxt[1:0]} - 3'd1;
          end
        end

        if (do_stop) begin
          dir_nxt  = DIR_HIGH;
          door_nxt = DUTY_OPEN;
          mask_nxt = mask_nxt & ~floor_bit(floor_nxt);
          ptmr_nxt = 16'd0;
          st_nxt   = ST_OPENING;
          if (open_r == 16'd0) begin
            dir_nxt  = DIR_STOP;
            door_nxt = DUTY_OFF;
            st_nxt   = ST_DWELL;
            do_dwell = 1'b1;
          end
        end

        if (do_dwell) begin
          if (mask_nxt != 4'd0) begin
            if (ptmr_nxt >= dwell_r) begin
              dir_nxt  = DIR_LOW;
              door_nxt = DUTY_CLOSE;
              ptmr_nxt = 16'd0;
              st_nxt   = ST_CLOSING;
            end
          end else begin
            do_idle = 1'b1;
          end
        end

        if (do_idle) begin
          // Replay presses latched while busy
          add      = pend_nxt & VALID_MASK & ~floor_bit(floor_nxt);
          pend_nxt = 4'd0;
          st_nxt   = ST_IDLE;
          if (add != 4'd0) begin
            mask_nxt = mask_nxt | add;
            ptmr_nxt = 16'd0;
            st_nxt   = ST_COLLECT;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      floor_r     <= 3'd1;
      mask_r      <= 4'd0;
      pend_r      <= 4'd0;
      up_r        <= 1'b0;
      dn_r        <= 1'b0;
      ptmr_r      <= 16'd0;
      ltmr_r      <= 16'd0;
      upos_r      <= UP_POS_FIRST;
      dpos_r      <= DOWN_POS_FIRST;
      nib_r       <= 4'd0;
      dir_r       <= DIR_STOP;
      motor_r     <= DUTY_OFF;
      door_r      <= DUTY_OFF;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      floor_r     <= floor_nxt;
      mask_r      <= mask_nxt;
      pend_r      <= pend_nxt;
      up_r        <= up_nxt;
      dn_r        <= dn_nxt;
      ptmr_r      <= ptmr_nxt;
      ltmr_r      <= ltmr_nxt;
      upos_r      <= upos_nxt;
      dpos_r      <= dpos_nxt;
      nib_r       <= nib_nxt;
      dir_r       <= dir_nxt;
      motor_r     <= motor_nxt;
      door_r      <= door_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result is the state left by the last accepted item; it holds while stalled
  always_comb begin
    case (st_r)
      ST_IDLE:    out_phase = PH_IDLE;
      ST_COLLECT: out_phase = PH_COLLECT;
      ST_CLOSING: out_phase = PH_CLOSING;
      ST_TRAVEL:  out_phase = PH_TRAVEL;
      ST_OPENING: out_phase = PH_OPENING;
      ST_DWELL:   out_phase = PH_DWELL;
      default:    out_phase = PH_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_floor_now      = floor_r;
  assign out_led_pattern    = {nib_r, mask_r};
  assign out_direction_line = dir_r;
  assign out_motor_duty     = motor_r;
  assign out_door_duty      = door_r;

endmodule
`default_nettype wire

>>> sv/elev_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elev_chk
// Port-level checks bound into every elevator_controller_core instance.
// ----------------------------------------------------------------------------
module elev_chk
  import elev_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_floor_now,
  input wire logic [3:0]  out_phase,
  input wire logic [7:0]  out_led_pattern,
  input wire logic [6:0]  out_motor_duty
);

  // Every accepted item yields a result on the next clock
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // Transient phases are resolved within the tick that enters them
  a_no_transient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase != PH_START_CLOSE) && (out_phase != PH_CHOOSE) &&
                  (out_phase != PH_ARRIVE) && (out_phase <= PH_DWELL))
    else $error("transient or unknown phase shown");

  a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_floor_now >= 3'd1) && (out_floor_now <= 3'(FLOORS)))
    else $error("floor out of range");

  // Lift motor runs only while traveling
  a_motor_travel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motor_duty != DUTY_OFF) |-> (out_phase == PH_TRAVEL))
    else $error("motor driven outside travel");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_floor_now) &&
                               $stable(out_phase) && $stable(out_led_pattern))
    else $error("stalled result changed");

endmodule

bind elevator_controller_core elev_chk u_elev_chk (.*);
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for elevator_controller_core: a clocked driver sends
// tick and button items from a queue in random bursts, a predictor computes
// the controller state after each accepted item, and a clocked monitor
// compares every result field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import elev_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_CAP      = 40;

  typedef struct packed {
    logic       op;
    logic [1:0] button_floor;
  } car_item_t;

  typedef struct packed {
    logic [2:0] floor_now;
    logic [3:0] phase;
    logic [7:0] led;
    logic [1:0] dir;
    logic [6:0] motor;
    logic [6:0] door;
  } car_view_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_op = 1'b0;
  logic [1:0]  in_button_floor = 2'd0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_wdata = 16'd0;

  wire         in_ready;
  wire         out_valid;
  wire [2:0]   out_floor_now;
  wire [3:0]   out_phase;
  wire [7:0]   out_led_pattern;
  wire [1:0]   out_direction_line;
  wire [6:0]   out_motor_duty;
  wire [6:0]   out_door_duty;

  elevator_controller_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_button_floor    (in_button_floor),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_floor_now      (out_floor_now),
    .out_phase          (out_phase),
    .out_led_pattern    (out_led_pattern),
    .out_direction_line (out_direction_line),
    .out_motor_duty     (out_motor_duty),
    .out_door_duty      (out_door_duty),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predicted controller state and its own copy of the timing registers
  logic [3:0]  car_phase;
  logic [2:0]  car_floor;
  logic [3:0]  req_bits;
  logic [3:0]  held_buttons;
  logic        move_up;
  logic        move_down;
  logic [15:0] phase_clk;
  logic [15:0] light_clk;
  logic [2:0]  up_pos;
  logic [2:0]  dn_pos;
  logic [3:0]  light_bits;
  logic [1:0]  dir_lvl;
  logic [6:0]  motor_lvl;
  logic [6:0]  door_lvl;
  logic [15:0] t_settle, t_close, t_travel, t_open, t_dwell, t_step;

  car_item_t   queued_events[$];
  car_view_t   expected_views[$];
  car_item_t   next_event;
  car_view_t   want_view;

  int unsigned events_queued = 0;
  int unsigned events_taken = 0;
  int unsigned n_press = 0;
  int unsigned n_tick = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] phases_seen = 16'd0;

  logic [7:0]  squeeze_req = 8'd0;
  logic [7:0]  squeeze_ack = 8'd0;
  int unsigned squeeze_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [1:0]  rx_count = 2'd0;

  function automatic void reset_car();
    car_phase    = PH_IDLE;
    car_floor    = 3'd1;
    req_bits     = 4'd0;
    held_buttons = 4'd0;
    move_up      = 1'b0;
    move_down    = 1'b0;
    phase_clk    = 16'd0;
    light_clk    = 16'd0;
    up_pos       = UP_POS_FIRST;
    dn_pos       = DOWN_POS_FIRST;
    light_bits   = 4'd0;
    dir_lvl      = DIR_STOP;
    motor_lvl    = DUTY_OFF;
    door_lvl     = DUTY_OFF;
    t_settle     = RST_SETTLE;
    t_close      = RST_CLOSE;
    t_travel     = RST_TRAVEL;
    t_open       = RST_OPEN;
    t_dwell      = RST_DWELL;
    t_step       = RST_LIGHT_STEP;
  endfunction

  function automatic logic [3:0] floor_onehot();
    return 4'b0001 << 2'(car_floor - 3'd1);
  endfunction

  // Presses for the current floor drop out; any other press restarts collecting
  function automatic void register_presses(input logic [3:0] btns);
    logic [3:0] fresh;
    fresh = btns & VALID_MASK & ~floor_onehot();
    if (fresh != 4'd0) begin
      req_bits  = req_bits | fresh;
      phase_clk = 16'd0;
      car_phase = PH_COLLECT;
    end
  endfunction

  function automatic void return_idle();
    logic [3:0] held;
    held         = held_buttons;
    held_buttons = 4'd0;
    car_phase    = PH_IDLE;
    register_presses(held);
  endfunction

  // One pass of the phase logic; returns 1 when the phase moved on
  function automatic bit run_phase();
    logic [3:0] here;
    here = floor_onehot();
    case (car_phase)
      PH_IDLE: return 1'b0;
      PH_COLLECT: begin
        if (phase_clk > t_settle) begin
          car_phase = PH_START_CLOSE;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_START_CLOSE: begin
        dir_lvl   = DIR_LOW;
        door_lvl  = DUTY_CLOSE;
        phase_clk = 16'd0;
        car_phase = PH_CLOSING;
        return 1'b1;
      end
      PH_CLOSING: begin
        if (phase_clk > t_close) begin
          dir_lvl   = DIR_STOP;
          door_lvl  = DUTY_OFF;
          car_phase = PH_CHOOSE;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_CHOOSE: begin
        if (req_bits > here && car_floor < FLOORS) begin
          move_up   = 1'b1;
          dir_lvl   = DIR_HIGH;
          motor_lvl = DUTY_UP;
        end else if (req_bits < here && car_floor > 3'd1) begin
          move_down = 1'b1;
          dir_lvl   = DIR_LOW;
          motor_lvl = DUTY_DOWN;
        end
        phase_clk = 16'd0;
        car_phase = PH_TRAVEL;
        return 1'b1;
      end
      PH_TRAVEL: begin
        if (phase_clk >= t_travel) begin
          if (move_up) begin
            if (car_floor < FLOORS) car_floor = car_floor + 3'd1;
            move_up = 1'b0;
          end else if (move_down) begin
            if (car_floor > 3'd1) car_floor = car_floor - 3'd1;
            move_down = 1'b0;
          end
          dir_lvl    = DIR_STOP;
          motor_lvl  = DUTY_OFF;
          light_bits = 4'd0;
          up_pos     = UP_POS_FIRST;
          dn_pos     = DOWN_POS_FIRST;
          car_phase  = PH_ARRIVE;
          return 1'b1;
        end
        if (light_clk >= t_step) begin
          light_clk = 16'd0;
          if (move_up) begin
            light_bits = 4'b0001 << up_pos[1:0];
            up_pos = (up_pos >= UP_POS_LAST) ? UP_POS_FIRST : {1'b1, up_pos[1:0]} + 3'd1;
          end else if (move_down) begin
            light_bits = 4'b0001 << dn_pos[1:0];
            dn_pos = (dn_pos <= DOWN_POS_LAST) ? DOWN_POS_FIRST : {1'b1, dn_pos[1:0]} - 3'd1;
          end
        end
        return 1'b0;
      end
      PH_ARRIVE: begin
        if ((req_bits & here) != 4'd0) begin
          dir_lvl   = DIR_HIGH;
          door_lvl  = DUTY_OPEN;
          req_bits  = req_bits & ~here;
          phase_clk = 16'd0;
          car_phase = PH_OPENING;
        end else begin
          car_phase = PH_CHOOSE;
        end
        return 1'b1;
      end
      PH_OPENING: begin
        if (phase_clk >= t_open) begin
          dir_lvl   = DIR_STOP;
          door_lvl  = DUTY_OFF;
          phase_clk = 16'd0;
          car_phase = PH_DWELL;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_DWELL: begin
        if (req_bits != 4'd0) begin
          if (phase_clk >= t_dwell) begin
            car_phase = PH_START_CLOSE;
            return 1'b1;
          end
          return 1'b0;
        end
        return_idle();
        return 1'b1;
      end
      default: begin
        return_idle();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic car_view_t step_car(input logic op, input logic [1:0] btn);
    car_view_t v;
    if (op == OP_PRESS) begin
      if (car_phase == PH_IDLE || car_phase == PH_COLLECT) register_presses(4'b0001 << btn);
      else held_buttons = held_buttons | (4'b0001 << btn);
    end else begin
      if (phase_clk != TIMER_MAX) phase_clk = phase_clk + 16'd1;
      if (light_clk != TIMER_MAX) light_clk = light_clk + 16'd1;
      // run through zero-length phases until one waits
      for (int n = 0; n < 64; n++) begin
        if (!run_phase()) break;
      end
    end
    v.floor_now = car_floor;
    v.phase     = car_phase;
    v.led       = {light_bits, req_bits};
    v.dir       = dir_lvl;
    v.motor     = motor_lvl;
    v.door      = door_lvl;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < PRINT_CAP) $display("tb_top: mismatch at result %0d: %s", n_checked, msg);
    n_errors++;
  endtask

  task automatic check_field(input string fname, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", fname, got, want));
  endtask

  // Driver: hold each item until taken, and may idle between bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_views.push_back(step_car(in_op, in_button_floor));
        events_taken++;
        if (in_op == OP_PRESS) n_press++;
        else n_tick++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_events.size() != 0) begin
          next_event = queued_events.pop_front();
          in_valid        <= 1'b1;
          in_op           <= next_event.op;
          in_button_floor <= next_event.button_floor;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 50);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (squeeze_req != squeeze_ack) begin
      squeeze_ack  <= squeeze_req;
      squeeze_left <= 64;
      out_ready    <= 1'b0;
    end else if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
      out_ready    <= 1'b0;
    end else begin
      rx_count <= (rx_count == 2'd2) ? 2'd0 : rx_count + 2'd1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= (rx_count == 2'd0);
      endcase
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, phase %0d", out_phase));
      end else begin
        want_view = expected_views.pop_front();
        check_field("floor_now", 8'(out_floor_now), 8'(want_view.floor_now));
        check_field("phase", 8'(out_phase), 8'(want_view.phase));
        check_field("led_pattern", out_led_pattern, want_view.led);
        check_field("direction_line", 8'(out_direction_line), 8'(want_view.dir));
        check_field("motor_duty", 8'(out_motor_duty), 8'(want_view.motor));
        check_field("door_duty", 8'(out_door_duty), 8'(want_view.door));
      end
      if (out_phase < 4'd15) phases_seen[out_phase] = 1'b1;
      else phases_seen[15] = 1'b1;
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: watchdog expired after %0d quiet cycles", idle_cycles);
        $display("tb_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic void queue_item(input logic op, input logic [1:0] btn);
    car_item_t it;
    it.op           = op;
    it.button_floor = btn;
    queued_events.push_back(it);
    events_queued++;
  endfunction

  task automatic put_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SETTLE:     t_settle = val;
      CFG_CLOSE:      t_close  = val;
      CFG_TRAVEL:     t_travel = val;
      CFG_OPEN:       t_open   = val;
      CFG_DWELL:      t_dwell  = val;
      CFG_LIGHT_STEP: t_step   = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [15:0] settle_v, close_v, travel_v, open_v, dwell_v,
                             step_v);
    put_reg(CFG_SETTLE, settle_v);
    put_reg(CFG_CLOSE, close_v);
    put_reg(CFG_TRAVEL, travel_v);
    put_reg(CFG_OPEN, open_v);
    put_reg(CFG_DWELL, dwell_v);
    put_reg(CFG_LIGHT_STEP, step_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Wait until every item is taken and every result checked, then let it settle
  task automatic wait_quiet();
    while (events_taken != events_queued || expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly button groups followed by runs of ticks, with stray presses mixed in
  task automatic queue_trips(input int unsigned n_items);
    int unsigned first_idx;
    first_idx = events_queued;
    while (events_queued - first_idx < n_items) begin
      repeat ($urandom_range(1, 3)) queue_item(OP_PRESS, 2'($urandom_range(0, 3)));
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 9) == 0) queue_item(OP_PRESS, 2'($urandom_range(0, 3)));
        else queue_item(OP_TICK, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    reset_car();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: ignored press for the current floor, collect, restart
    queue_item(OP_PRESS, 2'd0);
    queue_item(OP_PRESS, 2'd1);
    queue_item(OP_PRESS, 2'd2);
    queue_item(OP_PRESS, 2'd3);
    repeat (3) queue_item(OP_TICK, 2'd3);
    queue_item(OP_PRESS, 2'd3);
    queue_item(OP_TICK, 2'd0);
    wait_quiet();

    // Zero timers chain phases within a tick; zero light step steps every tick
    load_timing(16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0);
    repeat (3) queue_item(OP_TICK, 2'd1);
    queue_item(OP_PRESS, 2'd0);
    queue_item(OP_PRESS, 2'd3);
    repeat (11) queue_item(OP_TICK, 2'($urandom_range(0, 3)));
    wait_quiet();

    for (int p = 0; p < 5; p++) begin
      load_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)));
      if (p == 1) squeeze_req <= squeeze_req + 8'd1;
      queue_trips(66);
      wait_quiet();
    end

    load_timing(16'd2, 16'd3, 16'd4, 16'd2, 16'd2, 16'd1);
    queue_trips(24);
    wait_quiet();

    $display("tb_top: drove %0d items (%0d presses, %0d ticks), checked %0d results",
             events_taken, n_press, n_tick, n_checked);
    $display("tb_top: %0d timing settings, phase codes shown %b, %0d mismatches",
             n_settings, phases_seen, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
